@@ design/wwc_pkg.sv @@
package wwc_pkg;

    // pattern storage and match vector sizing
    localparam int PATTERN_MAX = 16;
    localparam int POS_W       = PATTERN_MAX + 1;
    localparam int LEN_W       = $clog2(PATTERN_MAX + 1);

    // line count limit
    localparam int LINE_MAX    = 1024;
    localparam int COUNT_W     = 10;
    localparam int COUNT_TOP   = (1 << COUNT_W) - 1;
    localparam int COUNT_CAP   = (LINE_MAX - 1 < COUNT_TOP) ? (LINE_MAX - 1) : COUNT_TOP;

    // configuration port
    localparam int CFG_W       = 64;
    localparam int CFG_IDX_W   = 2;
    localparam int PLEN_REG_W  = 5;

    localparam logic [CFG_IDX_W-1:0] CFG_PATTERN_LOW  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PATTERN_HIGH = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PATTERN_LEN  = 2'd2;

    localparam logic [CFG_W-1:0]      PATTERN_LOW_RST  = 64'd42;
    localparam logic [CFG_W-1:0]      PATTERN_HIGH_RST = 64'd0;
    localparam logic [PLEN_REG_W-1:0] PATTERN_LEN_RST  = 5'd1;

    // byte codes
    localparam logic [7:0] STAR_CHAR    = 8'd42;
    localparam logic [7:0] SPACE_CHAR   = 8'd32;
    localparam logic [7:0] NEWLINE_CHAR = 8'd10;

    typedef logic [POS_W-1:0] pos_t;

    // decoded pattern, shared by the config and match blocks
    typedef struct packed {
        logic [PATTERN_MAX-1:0][7:0] chars;
        logic [PATTERN_MAX-1:0]      used;
        logic [PATTERN_MAX-1:0]      star;
        pos_t                        mask;
        logic [LEN_W-1:0]            len;
    } pattern_t;

    // stars let an active position also skip ahead; prefix form, no ripple
    function automatic pos_t star_closure(pos_t v, logic [PATTERN_MAX-1:0] star, pos_t mask);
        pos_t r;
        logic acc;
        logic ok;
        r = '0;
        for (int i = 0; i < POS_W; i++)
        begin
            acc = 1'b0;
            for (int j = 0; j <= i; j++)
            begin
                ok = v[j];
                for (int k = j; k < i; k++)
                begin
                    ok = ok & star[k];
                end
                acc = acc | ok;
            end
            r[i] = acc;
        end
        return r & mask;
    endfunction

    // one text byte moves every active position
    function automatic pos_t advance(pos_t v, logic [7:0] c, pattern_t pat);
        pos_t nxt;
        nxt = '0;
        for (int i = 0; i < PATTERN_MAX; i++)
        begin
            if (v[i] && pat.used[i])
            begin
                if (pat.star[i])
                begin
                    nxt[i] = 1'b1;
                end
                else if (pat.chars[i] == c)
                begin
                    nxt[i+1] = 1'b1;
                end
            end
        end
        return star_closure(nxt, pat.star, pat.mask);
    endfunction

endpackage

@@ design/wwc_cfg.sv @@
module wwc_cfg (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_write,
    input  logic [wwc_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [wwc_pkg::CFG_W-1:0]      cfg_data,
    output wwc_pkg::pattern_t              pat
);
    import wwc_pkg::*;

    logic [CFG_W-1:0]      pat_low_reg;
    logic [CFG_W-1:0]      pat_high_reg;
    logic [PLEN_REG_W-1:0] pat_len_reg;
    logic [2*CFG_W-1:0]    packed_chars;
    logic [LEN_W-1:0]      len_used;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pat_low_reg  <= PATTERN_LOW_RST;
            pat_high_reg <= PATTERN_HIGH_RST;
            pat_len_reg  <= PATTERN_LEN_RST;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                CFG_PATTERN_LOW:  pat_low_reg  <= cfg_data;
                CFG_PATTERN_HIGH: pat_high_reg <= cfg_data;
                CFG_PATTERN_LEN:  pat_len_reg  <= cfg_data[PLEN_REG_W-1:0];
                default:          ;
            endcase
        end
    end

    assign packed_chars = {pat_high_reg, pat_low_reg};

    // lengths above the pattern store are clamped
    assign len_used = (pat_len_reg > PLEN_REG_W'(PATTERN_MAX)) ? LEN_W'(PATTERN_MAX)
                                                                : LEN_W'(pat_len_reg);

    always_comb
    begin
        pat.len = len_used;
        for (int i = 0; i < PATTERN_MAX; i++)
        begin
            pat.chars[i] = packed_chars[8*i +: 8];
            pat.used[i]  = (i < int'(len_used));
            pat.star[i]  = pat.used[i] && (packed_chars[8*i +: 8] == STAR_CHAR);
        end
        for (int i = 0; i < POS_W; i++)
        begin
            pat.mask[i] = (i <= int'(len_used));
        end
    end

endmodule

@@ design/wwc_match.sv @@
module wwc_match (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              step,
    input  logic [7:0]        byte_in,
    input  wwc_pkg::pattern_t pat,
    output logic              hit
);
    import wwc_pkg::*;

    logic word_open_reg;
    logic word_open_next;
    pos_t vec_reg;
    pos_t vec_next;
    pos_t start_vec;
    pos_t base_vec;
    logic is_break;

    assign is_break  = (byte_in == NEWLINE_CHAR) || (byte_in == SPACE_CHAR);
    assign start_vec = star_closure(pos_t'(1), pat.star, pat.mask);
    // a new word restarts from the start position
    assign base_vec  = word_open_reg ? vec_reg : start_vec;

    always_comb
    begin
        word_open_next = word_open_reg;
        vec_next       = vec_reg;
        if (step)
        begin
            if (is_break)
            begin
                word_open_next = 1'b0;
            end
            else
            begin
                word_open_next = 1'b1;
                vec_next       = advance(base_vec, byte_in, pat);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            word_open_reg <= 1'b0;
        end
        else
        begin
            word_open_reg <= word_open_next;
        end
    end

    always_ff @(posedge clk)
    begin
        vec_reg <= vec_next;
    end

    // the open word reached the final position
    assign hit = word_open_reg && vec_reg[pat.len];

endmodule

@@ design/wildcard_word_counter.sv @@
// channel   | valid         | stall         | payload
// ----------+---------------+---------------+-------------------------
// text in   | data_valid    | data_stall    | data_byte[7:0]
// count out | count_valid   | count_stall   | match_count[9:0]
// config    | cfg_write     | (none)        | cfg_index[1:0], cfg_data[63:0]
//
// one item per cycle unless the output register is full and stalled; a newline item's
// count is registered as it leaves the input register; the per-item cost is one pass of
// the match vector update between the input register and match vector / count registers
// rst_n clears control state and loads the pattern registers with "*", length 1
// count_stall holds the output register; the input register still takes one more item
// any held item waits while the output register is full and stalled
module wildcard_word_counter (
    input  logic                            clk,
    input  logic                            rst_n,
    // text in
    input  logic                            data_valid,
    output logic                            data_stall,
    input  logic [7:0]                      data_byte,
    // count out
    output logic                            count_valid,
    input  logic                            count_stall,
    output logic [wwc_pkg::COUNT_W-1:0]     match_count,
    // config write port
    input  logic                            cfg_write,
    input  logic [wwc_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [wwc_pkg::CFG_W-1:0]       cfg_data
);
    import wwc_pkg::*;

    pattern_t pat;

    // input register
    logic       in_valid_reg;
    logic       in_valid_next;
    logic [7:0] in_byte_reg;
    logic       in_accept;

    // work on the held item this cycle
    logic       step;
    logic       hit;
    logic       is_newline;
    logic       is_space;

    // line state
    logic [COUNT_W-1:0] total_reg;
    logic [COUNT_W-1:0] total_next;
    logic [COUNT_W-1:0] total_closed;
    logic [1:0]         seen_reg;
    logic [1:0]         seen_next;
    logic               give;

    // output register
    logic               out_valid_reg;
    logic               out_valid_next;
    logic [COUNT_W-1:0] count_reg;
    logic [COUNT_W-1:0] count_next;

    wwc_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .pat       (pat)
    );

    // the held item moves on unless it would land on a full, stalled output
    assign step       = in_valid_reg && (!out_valid_reg || !count_stall);
    assign data_stall = in_valid_reg && !step;
    assign in_accept  = data_valid && !data_stall;

    assign is_newline = (in_byte_reg == NEWLINE_CHAR);
    assign is_space   = (in_byte_reg == SPACE_CHAR);

    wwc_match u_match (
        .clk     (clk),
        .rst_n   (rst_n),
        .step    (step),
        .byte_in (in_byte_reg),
        .pat     (pat),
        .hit     (hit)
    );

    always_comb
    begin
        if (in_accept)
        begin
            in_valid_next = 1'b1;
        end
        else if (step)
        begin
            in_valid_next = 1'b0;
        end
        else
        begin
            in_valid_next = in_valid_reg;
        end
    end

    // closing a word adds its match, saturating at the count cap
    assign total_closed = (hit && (total_reg < COUNT_W'(COUNT_CAP))) ? total_reg + 1'b1
                                                                       : total_reg;
    // a line of exactly one byte gives no count
    assign give = is_newline && (seen_reg != 2'd1);

    always_comb
    begin
        total_next     = total_reg;
        seen_next      = seen_reg;
        out_valid_next = out_valid_reg;
        count_next     = count_reg;

        if (!count_stall)
        begin
            out_valid_next = 1'b0;
        end

        if (step)
        begin
            if (is_newline)
            begin
                total_next = '0;
                seen_next  = '0;
                if (give)
                begin
                    out_valid_next = 1'b1;
                    count_next     = total_closed;
                end
            end
            else
            begin
                if (seen_reg != 2'd2)
                begin
                    seen_next = seen_reg + 2'd1;
                end
                if (is_space)
                begin
                    total_next = total_closed;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            total_reg     <= '0;
            seen_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            total_reg     <= total_next;
            seen_reg      <= seen_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            in_byte_reg <= data_byte;
        end
        count_reg <= count_next;
    end

    assign count_valid = out_valid_reg;
    assign match_count = count_reg;

endmodule

@@ bench/tb_wildcard_word_counter.sv @@
module tb_wildcard_word_counter;
    import wwc_pkg::*;

    localparam int CLK_HALF       = 10;
    localparam int RESET_CYCLES   = 10;
    localparam int RANDOM_ITEMS   = 1450;
    // a count is registered as its newline item leaves the input, leave some margin
    localparam int SETTLE_CYCLES  = 6;
    localparam int CYCLE_LIMIT    = 800000;
    localparam int DIRECTED_N     = 20;

    logic                 clk;
    logic                 rst_n;
    logic                 data_valid;
    logic                 data_stall;
    logic [7:0]           data_byte;
    logic                 count_valid;
    logic                 count_stall;
    logic [COUNT_W-1:0]   match_count;
    logic                 cfg_write;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_W-1:0]     cfg_data;

    wildcard_word_counter i_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .data_valid  (data_valid),
        .data_stall  (data_stall),
        .data_byte   (data_byte),
        .count_valid (count_valid),
        .count_stall (count_stall),
        .match_count (match_count),
        .cfg_write   (cfg_write),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data)
    );

    // directed text, a count typed in where it is obvious
    typedef struct packed {
        logic [7:0]         ch;
        logic               typed;
        logic [COUNT_W-1:0] want;
    } text_row_t;

    text_row_t directed_text [DIRECTED_N] = '{
        '{NEWLINE_CHAR, 1'b1, 10'd0},   // empty line right after reset
        '{"a",          1'b0, 10'd0},
        '{NEWLINE_CHAR, 1'b0, 10'd0},   // one-byte line, no count
        '{SPACE_CHAR,   1'b0, 10'd0},
        '{NEWLINE_CHAR, 1'b0, 10'd0},   // a lone space is one byte too
        '{SPACE_CHAR,   1'b0, 10'd0},
        '{SPACE_CHAR,   1'b0, 10'd0},
        '{8'h00,        1'b0, 10'd0},   // lowest byte as a word
        '{SPACE_CHAR,   1'b0, 10'd0},
        '{SPACE_CHAR,   1'b0, 10'd0},
        '{8'hFF,        1'b0, 10'd0},   // highest byte starts a word
        '{"x",          1'b0, 10'd0},
        '{SPACE_CHAR,   1'b0, 10'd0},
        '{NEWLINE_CHAR, 1'b1, 10'd2},   // "*" takes both words
        '{STAR_CHAR,    1'b0, 10'd0},   // star bytes in the text are plain bytes
        '{STAR_CHAR,    1'b0, 10'd0},
        '{NEWLINE_CHAR, 1'b1, 10'd1},
        '{SPACE_CHAR,   1'b0, 10'd0},
        '{SPACE_CHAR,   1'b0, 10'd0},
        '{NEWLINE_CHAR, 1'b1, 10'd0}    // spaces only, no words
    };

    // predictor copy of the pattern registers
    logic [CFG_W-1:0]      pat_low;
    logic [CFG_W-1:0]      pat_high;
    logic [PLEN_REG_W-1:0] pat_len;

    // predictor copy of the matching state
    pos_t                  live_pos;
    bit                    word_busy;
    logic [COUNT_W-1:0]    hits_in_line;
    int unsigned           line_bytes;

    logic [COUNT_W-1:0]    expected_counts [$];
    logic [7:0]            text_buf [$];
    int                    mismatches;
    int                    random_sent;
    int unsigned           cycle_count;
    bit                    sender_calm;
    bit                    receiver_calm;

    // pattern length in use, clipped to the storage
    function automatic int pattern_span();
        int n;
        n = pat_len;
        return (n > PATTERN_MAX) ? PATTERN_MAX : n;
    endfunction

    function automatic logic [7:0] pattern_byte(int i);
        if (i < 8)
        begin
            return pat_low[8*i +: 8];
        end
        return pat_high[8*(i-8) +: 8];
    endfunction

    // an active star also stands for the empty run
    function automatic pos_t skip_stars(pos_t v);
        int   n;
        pos_t keep;
        n = pattern_span();
        keep = '0;
        for (int i = 0; i < n; i++)
        begin
            if (v[i] && pattern_byte(i) == STAR_CHAR)
            begin
                v[i+1] = 1'b1;
            end
        end
        for (int i = 0; i <= n; i++)
        begin
            keep[i] = 1'b1;
        end
        return v & keep;
    endfunction

    function automatic pos_t consume_byte(pos_t v, logic [7:0] c);
        int         n;
        pos_t       nxt;
        logic [7:0] p;
        n = pattern_span();
        nxt = '0;
        for (int i = 0; i < n; i++)
        begin
            if (v[i])
            begin
                p = pattern_byte(i);
                if (p == STAR_CHAR)
                begin
                    nxt[i] = 1'b1;
                end
                else if (p == c)
                begin
                    nxt[i+1] = 1'b1;
                end
            end
        end
        return skip_stars(nxt);
    endfunction

    function automatic void finish_word();
        if (word_busy && live_pos[pattern_span()] && hits_in_line < COUNT_CAP)
        begin
            hits_in_line++;
        end
        word_busy = 1'b0;
        live_pos  = skip_stars(pos_t'(1));
    endfunction

    // returns 1 when the byte ends a line that reports a count
    function automatic bit predict_count(logic [7:0] c, output logic [COUNT_W-1:0] total);
        bit gives;
        total = '0;
        if (c == NEWLINE_CHAR)
        begin
            gives = (line_bytes != 1);
            finish_word();
            total = hits_in_line;
            hits_in_line = '0;
            line_bytes = 0;
            return gives;
        end
        if (line_bytes < 2)
        begin
            line_bytes++;
        end
        if (c == SPACE_CHAR)
        begin
            finish_word();
            return 1'b0;
        end
        if (!word_busy)
        begin
            live_pos  = skip_stars(pos_t'(1));
            word_busy = 1'b1;
        end
        live_pos = consume_byte(live_pos, c);
        return 1'b0;
    endfunction

    function automatic logic [7:0] pick_letter();
        return 8'h61 + 8'($urandom_range(0, 2));
    endfunction

    // a word built to fit the current pattern, sometimes with one byte spoiled
    function automatic void add_matching_word();
        logic [7:0] word [$];
        int         n;
        int         k;
        n = pattern_span();
        for (int i = 0; i < n; i++)
        begin
            if (pattern_byte(i) == STAR_CHAR)
            begin
                k = $urandom_range(0, 3);
                repeat (k) word.push_back(pick_letter());
            end
            else
            begin
                word.push_back(pattern_byte(i));
            end
        end
        if (word.size() == 0)
        begin
            word.push_back(pick_letter());
        end
        if ($urandom_range(0, 3) == 0)
        begin
            word[$urandom_range(0, word.size() - 1)] = pick_letter();
        end
        foreach (word[i])
        begin
            text_buf.push_back(word[i]);
        end
    endfunction

    // letters or raw noise, the noise may hold spaces and newlines
    function automatic void add_random_word();
        int k;
        k = $urandom_range(1, 5);
        repeat (k)
        begin
            if ($urandom_range(0, 2) == 0)
            begin
                text_buf.push_back(8'($urandom_range(0, 255)));
            end
            else
            begin
                text_buf.push_back(pick_letter());
            end
        end
    endfunction

    function automatic void add_line();
        int         r;
        int         words;
        logic [7:0] c;
        r = $urandom_range(0, 99);
        if (r < 12 && r >= 5)
        begin
            // one-byte line
            c = 8'($urandom_range(0, 255));
            text_buf.push_back((c == NEWLINE_CHAR) ? SPACE_CHAR : c);
        end
        else if (r >= 12)
        begin
            if ($urandom_range(0, 4) == 0)
            begin
                text_buf.push_back(SPACE_CHAR);
            end
            words = $urandom_range(1, 6);
            for (int w = 0; w < words; w++)
            begin
                if (w > 0)
                begin
                    repeat ($urandom_range(1, 3)) text_buf.push_back(SPACE_CHAR);
                end
                if ($urandom_range(0, 99) < 65)
                begin
                    add_matching_word();
                end
                else
                begin
                    add_random_word();
                end
            end
            if ($urandom_range(0, 4) == 0)
            begin
                text_buf.push_back(SPACE_CHAR);
            end
        end
        text_buf.push_back(NEWLINE_CHAR);
    endfunction

    // one item on the text channel, predicted once it is taken
    task automatic send_byte(logic [7:0] c, logic typed, logic [COUNT_W-1:0] want);
        int                 gap;
        bit                 gives;
        logic [COUNT_W-1:0] total;
        gap = sender_calm ? 0 : $urandom_range(0, 19);
        if (gap > 0)
        begin
            data_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        data_valid <= 1'b1;
        data_byte  <= c;
        @(posedge clk);
        while (data_stall)
        begin
            @(posedge clk);
        end
        gives = predict_count(c, total);
        if (gives)
        begin
            expected_counts.push_back(typed ? want : total);
        end
    endtask

    task automatic send_text();
        foreach (text_buf[i])
        begin
            send_byte(text_buf[i], 1'b0, '0);
        end
        text_buf.delete();
        data_valid <= 1'b0;
    endtask

    // hold off until every count is in and the pipe has emptied
    task automatic wait_for_idle();
        while (expected_counts.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] value);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        case (idx)
            CFG_PATTERN_LOW:  pat_low  = value;
            CFG_PATTERN_HIGH: pat_high = value;
            CFG_PATTERN_LEN:  pat_len  = value[PLEN_REG_W-1:0];
            default:          ;
        endcase
    endtask

    // first phases pin the corner patterns, the rest are drawn
    task automatic load_pattern(int phase_no);
        logic [CFG_W-1:0]      lo;
        logic [CFG_W-1:0]      hi;
        logic [PLEN_REG_W-1:0] len;
        int                    r;
        case (phase_no)
            0:
            begin
                // all-zero registers, empty pattern
                lo  = '0;
                hi  = '0;
                len = '0;
            end
            1:
            begin
                // all ones, length past the storage
                lo  = '1;
                hi  = '1;
                len = '1;
            end
            2:
            begin
                // nul, newline and space as literals between stars
                lo  = {"b", STAR_CHAR, SPACE_CHAR, NEWLINE_CHAR, 8'h00, STAR_CHAR, STAR_CHAR, "a"};
                hi  = {$urandom, $urandom};
                len = 5'd8;
            end
            3:
            begin
                lo  = {8{STAR_CHAR}};
                hi  = {8{STAR_CHAR}};
                len = 5'd16;
            end
            default:
            begin
                r = $urandom_range(0, 9);
                if (r < 7)
                begin
                    for (int i = 0; i < 8; i++)
                    begin
                        lo[8*i +: 8] = ($urandom_range(0, 3) == 0) ? STAR_CHAR : pick_letter();
                        hi[8*i +: 8] = ($urandom_range(0, 3) == 0) ? STAR_CHAR : pick_letter();
                    end
                end
                else if (r < 9)
                begin
                    lo = {$urandom, $urandom};
                    hi = {$urandom, $urandom};
                end
                else
                begin
                    lo = {8{8'($urandom_range(0, 255))}};
                    hi = lo;
                end
                r = $urandom_range(0, 9);
                if (r == 0)
                begin
                    len = 5'd16;
                end
                else if (r == 1)
                begin
                    len = 5'($urandom_range(17, 31));
                end
                else if (r == 2)
                begin
                    len = 5'd1;
                end
                else if (r == 3)
                begin
                    len = 5'($urandom_range(0, 16));
                end
                else
                begin
                    len = 5'($urandom_range(1, 8));
                end
            end
        endcase
        wait_for_idle();
        write_reg(CFG_PATTERN_LOW, lo);
        write_reg(CFG_PATTERN_HIGH, hi);
        write_reg(CFG_PATTERN_LEN, CFG_W'(len));
        cfg_write <= 1'b0;
    endtask

    // free-running clock
    initial
    begin
        clk = 1'b0;
        forever #CLK_HALF clk = ~clk;
    end

    // watchdog on the cycle count
    initial
    begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("%0t: run stopped at the cycle limit", $time);
        $display("Regression FAIL");
        $finish;
    end

    // count channel: check each count taken, stall at random after it
    initial
    begin
        int                 hold;
        logic [COUNT_W-1:0] want;
        hold = 0;
        count_stall <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n && count_valid && !count_stall)
            begin
                if (expected_counts.size() == 0)
                begin
                    $display("%0t: unexpected count: expected none, got %0d",
                             $time, match_count);
                    mismatches++;
                end
                else
                begin
                    want = expected_counts.pop_front();
                    if (match_count !== want)
                    begin
                        $display("%0t: match_count mismatch: expected %0d, got %0d",
                                 $time, want, match_count);
                        mismatches++;
                    end
                end
                hold = receiver_calm ? 0 : $urandom_range(0, 19);
            end
            if (hold > 0)
            begin
                count_stall <= 1'b1;
                hold--;
            end
            else
            begin
                count_stall <= 1'b0;
            end
        end
    end

    // stimulus
    initial
    begin
        int phase_no;
        rst_n      <= 1'b0;
        data_valid <= 1'b0;
        data_byte  <= '0;
        cfg_write  <= 1'b0;
        cfg_index  <= CFG_PATTERN_LOW;
        cfg_data   <= '0;
        mismatches    = 0;
        random_sent   = 0;
        sender_calm   = 1'b0;
        receiver_calm = 1'b0;

        // predictor starts from the reset pattern "*", length 1
        pat_low      = PATTERN_LOW_RST;
        pat_high     = PATTERN_HIGH_RST;
        pat_len      = PATTERN_LEN_RST;
        word_busy    = 1'b0;
        hits_in_line = '0;
        line_bytes   = 0;
        live_pos     = skip_stars(pos_t'(1));

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed text on the reset pattern
        foreach (directed_text[i])
        begin
            send_byte(directed_text[i].ch, directed_text[i].typed, directed_text[i].want);
        end
        data_valid <= 1'b0;

        // random phases, each on a fresh pattern; a word may stay open across a write
        phase_no = 0;
        while (random_sent < RANDOM_ITEMS)
        begin
            load_pattern(phase_no);
            sender_calm   = ($urandom_range(0, 3) == 0);
            receiver_calm = ($urandom_range(0, 3) == 0);
            while (text_buf.size() < $urandom_range(30, 70))
            begin
                add_line();
            end
            if ($urandom_range(0, 4) == 0)
            begin
                add_matching_word();
            end
            random_sent += text_buf.size();
            send_text();
            phase_no++;
        end

        // drain
        while (expected_counts.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (SETTLE_CYCLES) @(posedge clk);

        if (mismatches == 0)
        begin
            $display("Regression PASS");
        end
        else
        begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule

@@ filelist.f @@
design/wwc_pkg.sv
design/wwc_cfg.sv
design/wwc_match.sv
design/wildcard_word_counter.sv
bench/tb_wildcard_word_counter.sv
